### src/ssid_pkg.sv
package ssid_pkg;

  // Fixed field widths of the item and result channels
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 6;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_DECIDE,
    ST_SHU_RD,
    ST_SHU_WR,
    ST_SHD_RD,
    ST_SHD_WR,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [CountW-1:0]        count_t;

endpackage

### src/ssid_in_if.sv
interface ssid_in_if import ssid_pkg::*; ();

  logic   valid;
  logic   ready;
  cmd_e   cmd;
  value_t value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);

endinterface

### src/ssid_out_if.sv
interface ssid_out_if import ssid_pkg::*; ();

  logic   valid;
  logic   ready;
  count_t count;
  value_t element;
  logic   has_element;
  logic   full_reject;
  logic   last;

  modport source (output valid, output count, output element, output has_element,
                  output full_reject, output last, input ready);
  modport sink   (input valid, input count, input element, input has_element,
                  input full_reject, input last, output ready);

endinterface

### src/sorted_set_insert_delete.sv
// Sorted set of up to CAPACITY distinct signed 32-bit values, kept in ascending
// order in a single-port-write, registered-read RAM. Each accepted item (insert
// or delete) is handled by a small sequencer round the key compare and the RAM
// read port. Every step reads the RAM and then acts on the registered data: the
// linear search reads each entry below the insertion point, the shift reads and
// writes each moved entry and the run of results reads each element (an empty
// set gives one result with no element). Around them come the last search step,
// the decision, the key write or final shift read, and the idle state in which
// the next item is taken. A result that waits for its transfer holds up the emit
// steps. The input is not ready until the last result of the run has been loaded
// into the output register. That register lets the next item in while the final
// result still waits for its transfer.
module sorted_set_insert_delete import ssid_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssid_in_if.sink           in_i,
  ssid_out_if.source        out_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            present_q, present_d;
  logic            reject_q, reject_d;
  cmd_e            cmd_q, cmd_d;
  value_t          key_q, key_d;

  logic [CntW-1:0] ptr_inc, ptr_dec;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  value_t           ram_wdata, ram_rdata;

  logic             out_load;
  logic             out_free;
  value_t           load_element;
  logic             load_has, load_last;

  logic             out_valid_q;
  count_t           out_count_q;
  value_t           out_element_q;
  logic             out_has_q, out_reject_q, out_last_q;

  ssid_ram #(
    .Width (ValueW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ptr_inc  = CntW'(ptr_q + 1'b1);
  assign ptr_dec  = CntW'(ptr_q - 1'b1);
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready = (state_q == ST_IDLE);

  // Sequencer: search, shift, then emit
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    pos_d        = pos_q;
    present_d    = present_q;
    reject_d     = reject_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    ram_we       = 1'b0;
    ram_waddr    = ptr_q[AddrW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = ptr_q[AddrW-1:0];
    out_load     = 1'b0;
    load_element = ram_rdata;
    load_has     = 1'b1;
    load_last    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d    = in_i.cmd;
          key_d    = in_i.value;
          ptr_d    = '0;
          reject_d = 1'b0;
          state_d  = ST_SEARCH_RD;
        end
      end
      ST_SEARCH_RD: begin
        if (ptr_q == cnt_q) begin
          pos_d     = ptr_q;
          present_d = 1'b0;
          state_d   = ST_DECIDE;
        end else begin
          state_d = ST_SEARCH_CMP;
        end
      end
      ST_SEARCH_CMP: begin
        if (ram_rdata < key_q) begin
          ptr_d   = ptr_inc;
          state_d = ST_SEARCH_RD;
        end else begin
          pos_d     = ptr_q;
          present_d = (ram_rdata == key_q);
          state_d   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ptr_d   = '0;
        state_d = ST_EMIT_RD;
        unique case (cmd_q)
          CMD_INSERT: begin
            if (!present_q) begin
              if (cnt_q == CapCnt) begin
                reject_d = 1'b1;
              end else begin
                ptr_d   = cnt_q;
                state_d = ST_SHU_RD;
              end
            end
          end
          CMD_DELETE: begin
            if (present_q) begin
              ptr_d   = pos_q;
              state_d = ST_SHD_RD;
            end
          end
          default: ;
        endcase
      end
      // Open a gap at the insertion point, top entry first
      ST_SHU_RD: begin
        ram_raddr = ptr_dec[AddrW-1:0];
        if (ptr_q == pos_q) begin
          ram_we    = 1'b1;
          ram_wdata = key_q;
          cnt_d     = CntW'(cnt_q + 1'b1);
          ptr_d     = '0;
          state_d   = ST_EMIT_RD;
        end else begin
          state_d = ST_SHU_WR;
        end
      end
      ST_SHU_WR: begin
        ram_we  = 1'b1;
        ptr_d   = ptr_dec;
        state_d = ST_SHU_RD;
      end
      // Close the hole left by a deleted entry
      ST_SHD_RD: begin
        ram_raddr = ptr_inc[AddrW-1:0];
        if (ptr_inc >= cnt_q) begin
          cnt_d   = CntW'(cnt_q - 1'b1);
          ptr_d   = '0;
          state_d = ST_EMIT_RD;
        end else begin
          state_d = ST_SHD_WR;
        end
      end
      ST_SHD_WR: begin
        ram_we  = 1'b1;
        ptr_d   = ptr_inc;
        state_d = ST_SHD_RD;
      end
      // Stream the set out, one element per read
      ST_EMIT_RD: begin
        if (out_free) begin
          if (cnt_q == '0) begin
            out_load     = 1'b1;
            load_element = '0;
            load_has     = 1'b0;
            load_last    = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_EMIT_LD;
          end
        end
      end
      ST_EMIT_LD: begin
        out_load  = 1'b1;
        load_last = (ptr_inc == cnt_q);
        ptr_d     = ptr_inc;
        state_d   = load_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold item and result payload
  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    pos_q     <= pos_d;
    present_q <= present_d;
    reject_q  <= reject_d;
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    if (out_load) begin
      out_count_q   <= CountW'(cnt_q);
      out_element_q <= load_element;
      out_has_q     <= load_has;
      out_reject_q  <= reject_q;
      out_last_q    <= load_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.count       = out_count_q;
  assign out_o.element     = out_element_q;
  assign out_o.has_element = out_has_q;
  assign out_o.full_reject = out_reject_q;
  assign out_o.last        = out_last_q;

  // The set never grows beyond the table
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CapCnt)
    else $error("entry count above capacity");

  // A gap is only opened when there is room for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHU_RD) |-> (cnt_q < CapCnt))
    else $error("shift up with a full table");

  // A new result only comes from the emit steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT_RD || state_q == ST_EMIT_LD))
    else $error("result loaded outside the emit steps");

  // An empty result is the only and last one of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_has_q) |-> (out_last_q && out_count_q == '0))
    else $error("empty result not marked last");

endmodule

### src/ssid_ram.sv
module ssid_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/tb_top.sv
module tb_top;
  import ssid_pkg::*;

  localparam int unsigned Capacity      = 32;
  localparam int unsigned MaxIdle       = 16;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles   = 300;
  localparam int unsigned TimeoutCycles = 2_000_000;

  // One result of a set listing, as the block should present it
  typedef struct packed {
    count_t count;
    value_t element;
    logic   has_element;
    logic   full_reject;
    logic   last;
  } listing_t;

  logic clk_i;
  logic rst_ni;

  ssid_in_if  in_if ();
  ssid_out_if out_if ();

  sorted_set_insert_delete #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Mirror of the set contents, ascending, and the listings still owed
  value_t   set_mirror[$];
  listing_t listing_q[$];

  bit sender_idle_en   = 1'b1;
  bit receiver_idle_en = 1'b1;
  bit hold_off_req     = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned ops_sent       = 0;
  int unsigned listings_seen  = 0;
  int unsigned rejects_seen   = 0;
  int unsigned peak_size      = 0;

  // Clock and reset
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.cmd      = CMD_INSERT;
    in_if.value    = '0;
    out_if.ready   = 1'b0;
  end

  // Apply one operation to the mirror and queue the listing it produces
  function automatic void apply_set_op(cmd_e op, value_t v);
    int       pos;
    bit       found;
    bit       refused;
    listing_t r;
    pos = 0;
    while (pos < set_mirror.size() && set_mirror[pos] < v) pos++;
    found   = (pos < set_mirror.size()) && (set_mirror[pos] == v);
    refused = 1'b0;
    if (op == CMD_INSERT) begin
      if (!found) begin
        if (set_mirror.size() >= Capacity) refused = 1'b1;
        else set_mirror.insert(pos, v);
      end
    end else if (found) begin
      set_mirror.delete(pos);
    end
    if (refused) rejects_seen++;
    if (set_mirror.size() > peak_size) peak_size = set_mirror.size();
    if (set_mirror.size() == 0) begin
      r = '{count: '0, element: '0, has_element: 1'b0, full_reject: refused, last: 1'b1};
      listing_q.push_back(r);
    end else begin
      for (int i = 0; i < set_mirror.size(); i++) begin
        r.count       = count_t'(set_mirror.size());
        r.element     = set_mirror[i];
        r.has_element = 1'b1;
        r.full_reject = refused;
        r.last        = (i == set_mirror.size() - 1);
        listing_q.push_back(r);
      end
    end
  endfunction

  function automatic bit in_set(value_t v);
    foreach (set_mirror[i]) if (set_mirror[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  // Half the time a narrow window so values collide, else extremes and full-range values
  function automatic value_t draw_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000 + value_t'($urandom_range(0, 3));
      1:       return 32'sh7FFF_FFFF - value_t'($urandom_range(0, 3));
      2, 3, 4: return value_t'($urandom);
      default: return value_t'($urandom_range(0, 60)) - 30;
    endcase
  endfunction

  function automatic value_t draw_absent();
    value_t v;
    do v = value_t'($urandom); while (in_set(v));
    return v;
  endfunction

  // Offer one operation and hold it until the transfer
  task automatic issue_op(cmd_e op, value_t v);
    int unsigned gap;
    logic        rdy;
    gap = sender_idle_en ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= op;
    in_if.value <= v;
    do begin
      @(negedge clk_i);
      rdy = in_if.ready;
      @(posedge clk_i);
    end while (rdy !== 1'b1);
    apply_set_op(op, v);
    ops_sent++;
  endtask

  // Receiver: stall per result, with an occasional long hold-off on request
  initial begin : listing_sink
    int unsigned gap;
    logic        took;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HoldOffCycles;
      end else begin
        gap = receiver_idle_en ? $urandom_range(0, MaxIdle) : 0;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        took = out_if.valid;
        @(posedge clk_i);
      end while (took !== 1'b1);
    end
  end

  function automatic void check_field(string name, value_t want, value_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each transferred result with the oldest one owed
  initial begin : check_listing
    listing_t got;
    listing_t want;
    logic     fire;
    forever begin
      @(negedge clk_i);
      fire = out_if.valid & out_if.ready;
      got  = '{count: out_if.count, element: out_if.element,
               has_element: out_if.has_element, full_reject: out_if.full_reject,
               last: out_if.last};
      @(posedge clk_i);
      if (fire === 1'b1) begin
        listings_seen++;
        if (listing_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got element %0d count %0d",
                   $time, got.element, got.count);
          mismatch_count++;
        end else begin
          want = listing_q.pop_front();
          check_field("count", value_t'(want.count), value_t'(got.count));
          check_field("element", want.element, got.element);
          check_field("has_element", value_t'(want.has_element),
                      value_t'(got.has_element));
          check_field("full_reject", value_t'(want.full_reject),
                      value_t'(got.full_reject));
          check_field("last", value_t'(want.last), value_t'(got.last));
        end
      end
    end
  end

  // Empty set, extremes, duplicates and missing deletes
  task automatic test_directed_cases();
    issue_op(CMD_DELETE, 32'sd5);
    issue_op(CMD_INSERT, 32'sd0);
    issue_op(CMD_INSERT, 32'sh7FFF_FFFF);
    issue_op(CMD_INSERT, 32'sh8000_0000);
    issue_op(CMD_INSERT, -32'sd1);
    issue_op(CMD_INSERT, 32'sd1);
    issue_op(CMD_INSERT, 32'sd0);
    issue_op(CMD_DELETE, 32'sd1000);
    issue_op(CMD_DELETE, 32'sh7FFF_FFFF);
    issue_op(CMD_DELETE, 32'sh8000_0000);
    issue_op(CMD_DELETE, 32'sd0);
    issue_op(CMD_DELETE, -32'sd1);
    issue_op(CMD_DELETE, 32'sd1);
    issue_op(CMD_DELETE, 32'sd0);
    issue_op(CMD_INSERT, 32'sh5555_5555);
    issue_op(CMD_INSERT, 32'shAAAA_AAAA);
    issue_op(CMD_DELETE, 32'sh5555_5555);
    issue_op(CMD_DELETE, 32'shAAAA_AAAA);
  endtask

  // Fill to capacity, push against the full table, then drain to empty
  task automatic test_fill_and_drain();
    int guard;
    guard = 0;
    while (set_mirror.size() < Capacity && guard < 200) begin
      issue_op(CMD_INSERT, draw_value());
      guard++;
    end
    repeat (3) issue_op(CMD_INSERT, draw_absent());
    if (!in_set(32'sh8000_0000)) issue_op(CMD_INSERT, 32'sh8000_0000);
    repeat (2) issue_op(CMD_INSERT, set_mirror[$urandom_range(0, set_mirror.size() - 1)]);
    while (set_mirror.size() > 0) begin
      if ($urandom_range(0, 3) != 0)
        issue_op(CMD_DELETE, set_mirror[$urandom_range(0, set_mirror.size() - 1)]);
      else
        issue_op(CMD_DELETE, draw_absent());
    end
    issue_op(CMD_DELETE, draw_value());
  endtask

  // Random mix; lean towards deletes when the set is large
  task automatic test_random_mix(int unsigned n_ops);
    int unsigned del_pct;
    for (int unsigned k = 0; k < n_ops; k++) begin
      if (k % 40 == 0) begin
        sender_idle_en   = ($urandom_range(0, 3) != 0);
        receiver_idle_en = ($urandom_range(0, 3) != 0);
      end
      del_pct = (set_mirror.size() > 24) ? 60 : 35;
      if ($urandom_range(0, 99) < del_pct) begin
        if (set_mirror.size() > 0 && $urandom_range(0, 3) != 0)
          issue_op(CMD_DELETE, set_mirror[$urandom_range(0, set_mirror.size() - 1)]);
        else
          issue_op(CMD_DELETE, draw_value());
      end else begin
        issue_op(CMD_INSERT, draw_value());
      end
    end
    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;
  endtask

  // Hold the receiver off while items keep coming, so the input stalls
  task automatic test_backpressure();
    sender_idle_en = 1'b0;
    hold_off_req   = 1'b1;
    repeat (14) begin
      if ($urandom_range(0, 2) == 0 && set_mirror.size() > 0)
        issue_op(CMD_DELETE, set_mirror[$urandom_range(0, set_mirror.size() - 1)]);
      else
        issue_op(CMD_INSERT, draw_value());
    end
    sender_idle_en = 1'b1;
  endtask

  initial begin : run_tests
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_fill_and_drain();
    test_random_mix(170);
    test_backpressure();
    test_fill_and_drain();
    in_if.valid <= 1'b0;
    // Let every owed result arrive, then watch for stragglers
    while (listing_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Ran %0d insert/delete operations, checked %0d results.", ops_sent, listings_seen);
    $display("Set reached %0d entries, %0d inserts refused on a full table, %0d mismatches.",
             peak_size, rejects_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(64'd10 * TimeoutCycles);
    $display("TEST FAILED");
    $finish;
  end

endmodule
